### src/slt_pkg.sv
// shared types, constants and widths of the sauvola local threshold block
`default_nettype none
package slt_pkg;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_WINDOW_DEF = 31;

	localparam int PIX_W   = 8;
	localparam int IMG_W_W = 11;
	localparam int IMG_H_W = 13;
	localparam int WIN_W   = 5;
	localparam int K_W     = 16;
	localparam int R_W     = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_K_GAIN       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_RANGE    = 3'd4;

	localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [WIN_W-1:0]   RST_WINDOW_SIZE  = 5'd11;
	localparam logic [K_W-1:0]     RST_K_GAIN       = 16'd9830;
	localparam logic [R_W-1:0]     RST_DEV_RANGE    = 8'd50;

	// sized for the largest supported window
	localparam int SUM_W  = 20;
	localparam int SQ_W   = 28;
	localparam int N_W    = 12;
	localparam int NN_W   = 24;
	localparam int NUM_W  = 40;
	localparam int MEAN_W = 16;
	localparam int VAR_W  = 32;
	localparam int SD_W   = 16;
	localparam int D_W    = 24;
	localparam int KD_W   = 40;
	localparam int F_W    = 41;
	localparam int MF_W   = 57;

	localparam int MUL_A_W = 20;
	localparam int MUL_B_W = 41;
	localparam int MUL_P_W = 61;
	localparam int DIV_N_W = 56;
	localparam int DIV_D_W = 24;
	localparam int SQ_IN_W = 32;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} arith_op_t;

	typedef enum logic [3:0] {
		ST_NN,
		ST_NQ,
		ST_SS,
		ST_MEAN,
		ST_VAR,
		ST_SD,
		ST_D,
		ST_KD,
		ST_MF
	} step_t;

	typedef struct packed {
		logic  in_take;
		logic  win_start;
		logic  win_run;
		logic  pix_read;
		logic  pix_load;
		logic  op_start;
		step_t step;
		logic  op_capture;
		logic  emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_due;
		logic win_done;
		logic op_done;
		logic f_pos;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

### src/slt_ram.sv
// generic single-port ram with registered read
`default_nettype none
module slt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### src/slt_arith.sv
// iterative multiplier, restoring divider and integer square root sharing one control
`default_nettype none
module slt_arith (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire slt_pkg::arith_op_t            op,
	input  wire logic [slt_pkg::DIV_N_W-1:0]   opa,
	input  wire logic [slt_pkg::MUL_B_W-1:0]   opb,
	output logic                               done,
	output logic      [slt_pkg::MUL_P_W-1:0]   result
);
	localparam int PW  = slt_pkg::MUL_P_W;
	localparam int AW  = slt_pkg::MUL_A_W;
	localparam int NW  = slt_pkg::DIV_N_W;
	localparam int DW  = slt_pkg::DIV_D_W;
	localparam int QW  = slt_pkg::SQ_IN_W;
	localparam int CW  = $clog2(NW + 1);

	logic               busy_q;
	logic               done_q;
	slt_pkg::arith_op_t op_q;
	logic [CW-1:0]      cnt_q;
	logic [PW-1:0]      acc_q;
	logic [PW-1:0]      mc_q;
	logic [AW-1:0]      mp_q;
	logic [NW-1:0]      quo_q;
	logic [DW:0]        rem_q;
	logic [DW-1:0]      dvs_q;
	logic [QW-1:0]      sv_q;
	logic [QW-1:0]      sres_q;
	logic [QW-1:0]      sbit_q;

	logic [DW:0] rem_sh;
	logic        rem_ge;
	logic [DW:0] rem_nx;
	logic [QW:0] trial;
	logic        sq_ge;

	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		rem_ge = rem_sh >= {1'b0, dvs_q};
		rem_nx = rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
		trial  = {1'b0, sres_q} + {1'b0, sbit_q};
		sq_ge  = {1'b0, sv_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= slt_pkg::OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= op;
				case (op)
					slt_pkg::OP_MUL:  cnt_q <= CW'(AW - 1);
					slt_pkg::OP_DIV:  cnt_q <= CW'(NW - 1);
					slt_pkg::OP_SQRT: cnt_q <= CW'(QW / 2 - 1);
					default:          cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mc_q   <= PW'(opb);
			mp_q   <= opa[AW-1:0];
			quo_q  <= opa;
			rem_q  <= '0;
			dvs_q  <= opb[DW-1:0];
			sv_q   <= opa[QW-1:0];
			sres_q <= '0;
			sbit_q <= QW'(1) << (QW - 2);
		end else if (busy_q) begin
			case (op_q)
				slt_pkg::OP_MUL: begin
					if (mp_q[0]) begin
						acc_q <= acc_q + mc_q;
					end
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
				end
				slt_pkg::OP_DIV: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[NW-2:0], rem_ge};
				end
				slt_pkg::OP_SQRT: begin
					if (sq_ge) begin
						sv_q   <= sv_q - trial[QW-1:0];
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			slt_pkg::OP_MUL:  result = acc_q;
			slt_pkg::OP_DIV:  result = PW'(quo_q);
			slt_pkg::OP_SQRT: result = PW'(sres_q);
			default:          result = '0;
		endcase
	end

	assign done = done_q;
endmodule
`default_nettype wire

### src/slt_ctrl.sv
// controller state machine: input beat, window sweep, arithmetic sequence, output beat
`default_nettype none
module slt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire slt_pkg::dp_stat_t  stat,
	output slt_pkg::ctrl_cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_WIN,
		S_PIX,
		S_PIXW,
		S_OP_GO,
		S_OP_WAIT,
		S_FCHK,
		S_DONE
	} state_t;

	state_t          state_q;
	slt_pkg::step_t  step_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.step       = step_q;
		cmd.in_take    = (state_q == S_IDLE) && s_tvalid;
		cmd.win_start  = (state_q == S_CHECK) && stat.out_due;
		cmd.win_run    = (state_q == S_WIN);
		cmd.pix_read   = (state_q == S_PIX);
		cmd.pix_load   = (state_q == S_PIXW);
		cmd.op_start   = (state_q == S_OP_GO);
		cmd.op_capture = (state_q == S_OP_WAIT) && stat.op_done;
		cmd.emit       = (state_q == S_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= slt_pkg::ST_NN;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= stat.out_due ? S_WIN : S_IDLE;
				end
				S_WIN: begin
					if (stat.win_done) begin
						state_q <= S_PIX;
					end
				end
				S_PIX: begin
					state_q <= S_PIXW;
				end
				S_PIXW: begin
					step_q  <= slt_pkg::ST_NN;
					state_q <= S_OP_GO;
				end
				S_OP_GO: begin
					state_q <= S_OP_WAIT;
				end
				S_OP_WAIT: begin
					if (stat.op_done) begin
						case (step_q)
							slt_pkg::ST_KD: state_q <= S_FCHK;
							slt_pkg::ST_MF: state_q <= S_DONE;
							default: begin
								step_q  <= slt_pkg::step_t'(step_q + 4'd1);
								state_q <= S_OP_GO;
							end
						endcase
					end
				end
				S_FCHK: begin
					// a non-positive factor makes the product compare trivially
					if (stat.f_pos) begin
						step_q  <= slt_pkg::ST_MF;
						state_q <= S_OP_GO;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### src/slt_dp.sv
// datapath: config registers, positions, row ring, window sums, threshold math, output register
`default_nettype none
module slt_dp #(
	parameter int MAX_WIDTH  = slt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = slt_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [slt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [slt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [slt_pkg::PIX_W-1:0]         s_tdata,
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [slt_pkg::PIX_W-1:0]         m_tdata,
	output logic                                   m_tlast,
	input  wire slt_pkg::ctrl_cmd_t                cmd,
	output slt_pkg::dp_stat_t                      stat
);
	localparam int XB   = $clog2(MAX_WIDTH);
	localparam int RB   = $clog2(MAX_WINDOW + 1);
	localparam int HLIM = (MAX_WINDOW - 1) / 2;
	localparam int HB   = $clog2(HLIM + 1);
	localparam int SB   = HB + 1;
	localparam int YW   = slt_pkg::IMG_H_W;
	localparam int XS   = ((XB > SB) ? XB : SB) + 1;
	localparam int YS   = ((YW > SB) ? YW : SB) + 1;
	localparam int AW   = RB + XB;
	localparam int PW   = slt_pkg::PIX_W;

	logic [slt_pkg::IMG_W_W-1:0] img_w_q;
	logic [slt_pkg::IMG_H_W-1:0] img_h_q;
	logic [slt_pkg::WIN_W-1:0]   win_q;
	logic [slt_pkg::K_W-1:0]     k_q;
	logic [slt_pkg::R_W-1:0]     r_q;

	logic [XB:0]   w_eff;
	logic [XB:0]   w_m1;
	logic [YW-1:0] h_eff;
	logic [YW-1:0] h_m1;
	logic [HB-1:0] half;
	logic [SB-1:0] side_m1;
	logic [SB-1:0] side;
	logic [2*SB-1:0] n_full;
	logic [slt_pkg::N_W-1:0] n;
	logic [slt_pkg::R_W-1:0] r_eff;

	logic [XB-1:0] ix_q, ox_q;
	logic [YW-1:0] iy_q, oy_q;
	logic          cfg_hit;
	logic          in_write;
	logic          ix_last, ox_last, oy_last;

	logic [YS-1:0] ny_full;
	logic [YW-1:0] ny;
	logic [XS-1:0] nx_full;
	logic [XB-1:0] nx;
	logic          started;

	logic [SB-1:0] wy_q, wx_q;
	logic          iss_q;
	logic          rd_v_s1;
	logic [YS-1:0] yy_raw, yy_off;
	logic [YW-1:0] yy;
	logic [XS-1:0] xx_raw, xx_off;
	logic [XB-1:0] xx;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [PW-1:0] ram_rdata;

	logic [slt_pkg::SUM_W-1:0]  sum_q;
	logic [slt_pkg::SQ_W-1:0]   sq_q;
	logic [2*PW-1:0]            pp;
	logic [PW-1:0]              pix_q;

	logic [slt_pkg::NN_W-1:0]   nn_q;
	logic [slt_pkg::NUM_W-1:0]  nq_q, ss_q, num;
	logic [slt_pkg::MEAN_W-1:0] mean_q;
	logic [slt_pkg::VAR_W-1:0]  var_q;
	logic [slt_pkg::SD_W-1:0]   sd_q;
	logic [slt_pkg::D_W-1:0]    d_q;
	logic [slt_pkg::KD_W-1:0]   kd_q;
	logic [slt_pkg::MF_W-1:0]   mf_q;
	logic [slt_pkg::F_W:0]      fsum;
	logic [slt_pkg::F_W-1:0]    f_u;
	logic                       f_pos;
	logic                       below;

	slt_pkg::arith_op_t              op;
	logic [slt_pkg::DIV_N_W-1:0]     opa;
	logic [slt_pkg::MUL_B_W-1:0]     opb;
	logic                            op_done;
	logic [slt_pkg::MUL_P_W-1:0]     op_res;

	logic          mvalid_q;
	logic [PW-1:0] mdata_q;
	logic          mlast_q;

	// configuration
	assign cfg_hit = cfg_we && (cfg_index <= slt_pkg::CFG_DEV_RANGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= slt_pkg::RST_IMAGE_WIDTH;
			img_h_q <= slt_pkg::RST_IMAGE_HEIGHT;
			win_q   <= slt_pkg::RST_WINDOW_SIZE;
			k_q     <= slt_pkg::RST_K_GAIN;
			r_q     <= slt_pkg::RST_DEV_RANGE;
		end else if (cfg_we) begin
			case (cfg_index)
				slt_pkg::CFG_IMAGE_WIDTH:  img_w_q <= cfg_data[slt_pkg::IMG_W_W-1:0];
				slt_pkg::CFG_IMAGE_HEIGHT: img_h_q <= cfg_data[slt_pkg::IMG_H_W-1:0];
				slt_pkg::CFG_WINDOW_SIZE:  win_q   <= cfg_data[slt_pkg::WIN_W-1:0];
				slt_pkg::CFG_K_GAIN:       k_q     <= cfg_data[slt_pkg::K_W-1:0];
				slt_pkg::CFG_DEV_RANGE:    r_q     <= cfg_data[slt_pkg::R_W-1:0];
				default:                   k_q     <= k_q;
			endcase
		end
	end

	always_comb begin
		if (img_w_q == '0) begin
			w_eff = (XB + 1)'(1);
		end else if (32'(img_w_q) > MAX_WIDTH) begin
			w_eff = (XB + 1)'(MAX_WIDTH);
		end else begin
			w_eff = (XB + 1)'(img_w_q);
		end
		w_m1  = w_eff - (XB + 1)'(1);
		h_eff = (img_h_q == '0) ? YW'(1) : img_h_q;
		h_m1  = h_eff - YW'(1);
		if (32'(win_q[slt_pkg::WIN_W-1:1]) > HLIM) begin
			half = HB'(HLIM);
		end else begin
			half = HB'(win_q[slt_pkg::WIN_W-1:1]);
		end
		side_m1 = {half, 1'b0};
		side    = {half, 1'b1};
		n_full  = side * side;
		n       = slt_pkg::N_W'(n_full);
		r_eff   = (r_q == '0) ? slt_pkg::R_W'(1) : r_q;
	end

	// positions and readiness of the next output
	assign in_write = cmd.in_take && !s_tuser && (iy_q < h_eff);
	assign ix_last  = ((XB + 1)'(ix_q) == w_m1);
	assign ox_last  = ((XB + 1)'(ox_q) == w_m1);
	assign oy_last  = (oy_q == h_m1);

	always_comb begin
		ny_full = YS'(oy_q) + YS'(half);
		ny      = (ny_full > YS'(h_m1)) ? h_m1 : ny_full[YW-1:0];
		nx_full = XS'(ox_q) + XS'(half);
		nx      = (nx_full > XS'(w_m1)) ? w_m1[XB-1:0] : nx_full[XB-1:0];
		started = (ix_q != '0) || (iy_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ix_q <= '0;
			iy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else if (cfg_hit) begin
			ix_q <= '0;
			iy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
		end else if (in_write) begin
			if (ix_last) begin
				ix_q <= '0;
				iy_q <= iy_q + YW'(1);
			end else begin
				ix_q <= ix_q + XB'(1);
			end
		end else if (cmd.emit) begin
			if (ox_last) begin
				ox_q <= '0;
				if (oy_last) begin
					// frame complete, both sides start over
					oy_q <= '0;
					ix_q <= '0;
					iy_q <= '0;
				end else begin
					oy_q <= oy_q + YW'(1);
				end
			end else begin
				ox_q <= ox_q + XB'(1);
			end
		end
	end

	// window sweep with replicated borders
	always_comb begin
		yy_raw = YS'(oy_q) + YS'(wy_q);
		yy_off = yy_raw - YS'(half);
		if (yy_raw < YS'(half)) begin
			yy = '0;
		end else if (yy_off > YS'(h_m1)) begin
			yy = h_m1;
		end else begin
			yy = yy_off[YW-1:0];
		end
		xx_raw = XS'(ox_q) + XS'(wx_q);
		xx_off = xx_raw - XS'(half);
		if (xx_raw < XS'(half)) begin
			xx = '0;
		end else if (xx_off > XS'(w_m1)) begin
			xx = w_m1[XB-1:0];
		end else begin
			xx = xx_off[XB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wy_q    <= '0;
			wx_q    <= '0;
			iss_q   <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.win_run && iss_q;
			if (cmd.win_start) begin
				wy_q  <= '0;
				wx_q  <= '0;
				iss_q <= 1'b1;
			end else if (cmd.win_run && iss_q) begin
				if (wx_q == side_m1) begin
					wx_q <= '0;
					if (wy_q == side_m1) begin
						iss_q <= 1'b0;
					end else begin
						wy_q <= wy_q + SB'(1);
					end
				end else begin
					wx_q <= wx_q + SB'(1);
				end
			end
		end
	end

	always_comb begin
		ram_we = in_write;
		if (cmd.in_take) begin
			ram_addr = {iy_q[RB-1:0], ix_q};
		end else if (cmd.pix_read) begin
			ram_addr = {oy_q[RB-1:0], ox_q};
		end else begin
			ram_addr = {yy[RB-1:0], xx};
		end
	end

	slt_ram #(
		.WIDTH (PW),
		.DEPTH (2 ** AW)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (s_tdata),
		.rdata (ram_rdata)
	);

	assign pp = (2 * PW)'(ram_rdata) * (2 * PW)'(ram_rdata);

	always_ff @(posedge clk) begin
		if (cmd.win_start) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (rd_v_s1) begin
			sum_q <= sum_q + slt_pkg::SUM_W'(ram_rdata);
			sq_q  <= sq_q + slt_pkg::SQ_W'(pp);
		end
		if (cmd.pix_load) begin
			pix_q <= ram_rdata;
		end
	end

	// threshold arithmetic
	assign num = (nq_q > ss_q) ? nq_q - ss_q : '0;

	always_comb begin
		fsum  = (slt_pkg::F_W + 1)'(kd_q) + ((slt_pkg::F_W + 1)'(1) << 32)
			- ((slt_pkg::F_W + 1)'(k_q) << 16);
		f_pos = !fsum[slt_pkg::F_W] && (fsum != '0);
		f_u   = fsum[slt_pkg::F_W-1:0];
		below = f_pos && (slt_pkg::MF_W'({pix_q, 40'd0}) < mf_q);
	end

	always_comb begin
		op  = slt_pkg::OP_MUL;
		opa = '0;
		opb = '0;
		case (cmd.step)
			slt_pkg::ST_NN: begin
				opa = slt_pkg::DIV_N_W'(n);
				opb = slt_pkg::MUL_B_W'(n);
			end
			slt_pkg::ST_NQ: begin
				opa = slt_pkg::DIV_N_W'(n);
				opb = slt_pkg::MUL_B_W'(sq_q);
			end
			slt_pkg::ST_SS: begin
				opa = slt_pkg::DIV_N_W'(sum_q);
				opb = slt_pkg::MUL_B_W'(sum_q);
			end
			slt_pkg::ST_MEAN: begin
				op  = slt_pkg::OP_DIV;
				opa = slt_pkg::DIV_N_W'({sum_q, 8'd0});
				opb = slt_pkg::MUL_B_W'(n);
			end
			slt_pkg::ST_VAR: begin
				op  = slt_pkg::OP_DIV;
				opa = {num, 16'd0};
				opb = slt_pkg::MUL_B_W'(nn_q);
			end
			slt_pkg::ST_SD: begin
				op  = slt_pkg::OP_SQRT;
				opa = slt_pkg::DIV_N_W'(var_q);
			end
			slt_pkg::ST_D: begin
				op  = slt_pkg::OP_DIV;
				opa = slt_pkg::DIV_N_W'({sd_q, 8'd0});
				opb = slt_pkg::MUL_B_W'(r_eff);
			end
			slt_pkg::ST_KD: begin
				opa = slt_pkg::DIV_N_W'(k_q);
				opb = slt_pkg::MUL_B_W'(d_q);
			end
			slt_pkg::ST_MF: begin
				opa = slt_pkg::DIV_N_W'(mean_q);
				opb = f_u;
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	slt_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op_start),
		.op     (op),
		.opa    (opa),
		.opb    (opb),
		.done   (op_done),
		.result (op_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.op_capture) begin
			case (cmd.step)
				slt_pkg::ST_NN:   nn_q   <= op_res[slt_pkg::NN_W-1:0];
				slt_pkg::ST_NQ:   nq_q   <= op_res[slt_pkg::NUM_W-1:0];
				slt_pkg::ST_SS:   ss_q   <= op_res[slt_pkg::NUM_W-1:0];
				slt_pkg::ST_MEAN: mean_q <= op_res[slt_pkg::MEAN_W-1:0];
				slt_pkg::ST_VAR:  var_q  <= op_res[slt_pkg::VAR_W-1:0];
				slt_pkg::ST_SD:   sd_q   <= op_res[slt_pkg::SD_W-1:0];
				slt_pkg::ST_D:    d_q    <= op_res[slt_pkg::D_W-1:0];
				slt_pkg::ST_KD:   kd_q   <= op_res[slt_pkg::KD_W-1:0];
				slt_pkg::ST_MF:   mf_q   <= op_res[slt_pkg::MF_W-1:0];
				default:          nn_q   <= nn_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			mdata_q <= below ? '0 : '1;
			mlast_q <= ox_last && oy_last;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tlast  = mlast_q;

	always_comb begin
		stat          = '0;
		stat.out_due  = started && ((iy_q > ny) || ((iy_q == ny) && (ix_q > nx)));
		stat.win_done = !iss_q && !rd_v_s1;
		stat.op_done  = op_done;
		stat.f_pos    = f_pos;
		stat.out_free = !mvalid_q || m_tready;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!mvalid_q || m_tready))
		else $error("result loaded over an untaken beat");

	a_take_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_take |-> !rd_v_s1)
		else $error("input beat taken during a window read");

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		(XB + 1)'(ix_q) < w_eff)
		else $error("input column beyond row width");

	a_mf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op_capture && (cmd.step == slt_pkg::ST_MF)) |-> f_pos)
		else $error("product taken with a non-positive factor");
endmodule
`default_nettype wire

### src/sauvola_local_threshold.sv
// Sauvola local threshold binarizer for an 8-bit raster pixel stream. Pixels
// (tuser 0) and drain beats (tuser 1) are taken one at a time; a beat that
// releases no result goes from the check state straight back to idle. When
// a result is due, a sequencer reads the (2h+1)^2 window pixels from the row
// ring one per cycle, then runs the mean, variance, square root and threshold
// product through one shared iterative arithmetic unit. The output register
// lets a finished result wait while the next beat is accepted. Configuration
// writes restart the frame and need no wait after reset.
`default_nettype none
module sauvola_local_threshold #(
	parameter int MAX_WIDTH  = slt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW = slt_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [slt_pkg::PIX_W-1:0]       s_tdata,   // pixel_in
	input  wire logic                            s_tuser,   // func
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [slt_pkg::PIX_W-1:0]       m_tdata,   // pixel_out
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [slt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [slt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	slt_pkg::ctrl_cmd_t cmd;
	slt_pkg::dp_stat_t  stat;

	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	slt_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule
`default_nettype wire
